/* hw/rtl/trp_pkg.sv */
// Shared types and constants of the Thumb relocation patcher.
package trp_pkg;

   // ELF relocation type codes
   localparam logic [7:0] TYPE_ABS32      = 8'd2;
   localparam logic [7:0] TYPE_THM_CALL   = 8'd10;
   localparam logic [7:0] TYPE_THM_JUMP24 = 8'd30;
   localparam logic [7:0] TYPE_THM_MOVW   = 8'd47;
   localparam logic [7:0] TYPE_THM_MOVT   = 8'd48;

   // Status codes
   localparam logic [1:0] ST_OK          = 2'd0;
   localparam logic [1:0] ST_RANGE       = 2'd1;
   localparam logic [1:0] ST_UNSUPPORTED = 2'd2;

   // Fixed Thumb pipeline offset of a branch
   localparam logic [31:0] PC_OFFSET = 32'd4;

   typedef enum logic [2:0] {
      OP_ABS32,
      OP_BRANCH,
      OP_MOVW,
      OP_MOVT,
      OP_BAD
   } op_type;

   typedef struct packed {
      logic [7:0]  action;
      logic [31:0] insn_word;
      logic [31:0] place_address;
      logic [31:0] symbol_address;
   } req_type;

   typedef struct packed {
      logic [31:0] patched_word;
      logic [1:0]  status;
   } rsp_type;

   // Decode stage contents
   typedef struct packed {
      op_type      op;
      logic [31:0] word;
      logic [31:0] place4;
      logic [31:0] sym;
      logic [31:0] addend;
   } dec_type;

   // Adder stage contents
   typedef struct packed {
      op_type      op;
      logic [31:0] word;
      logic [31:0] sum;
   } sum_type;

endpackage

/* hw/rtl/trp_decode.sv */
// Stage 1: type decode, MOVW/MOVT addend extraction, place + 4.
module trp_decode (
   input  logic              clock,
   input  logic              reset,
   input  logic              valid,
   input  trp_pkg::req_type  req,
   output logic              valid_ff,
   output trp_pkg::dec_type  dec_ff
);
   import trp_pkg::*;

   logic    valid_in;
   dec_type dec_in;
   op_type  op;
   logic [15:0] imm16;

   always_comb begin
      case (req.action)
         TYPE_ABS32:      op = OP_ABS32;
         TYPE_THM_CALL:   op = OP_BRANCH;
         TYPE_THM_JUMP24: op = OP_BRANCH;
         TYPE_THM_MOVW:   op = OP_MOVW;
         TYPE_THM_MOVT:   op = OP_MOVT;
         default:         op = OP_BAD;
      endcase
   end

   // imm4:i:imm3:imm8 spread over both halfwords
   assign imm16 = {req.insn_word[3:0], req.insn_word[10], req.insn_word[30:28],
                   req.insn_word[23:16]};

   always_comb begin
      valid_in       = valid;
      dec_in.op      = op;
      dec_in.word    = req.insn_word;
      dec_in.place4  = req.place_address + PC_OFFSET;
      dec_in.sym     = req.symbol_address;
      dec_in.addend  = {{16{imm16[15]}}, imm16};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dec_ff <= dec_in;
   end

endmodule

/* hw/rtl/trp_arith.sv */
// Stage 2: one shared 32-bit adder for all relocation kinds.
module trp_arith (
   input  logic              clock,
   input  logic              reset,
   input  logic              valid,
   input  trp_pkg::dec_type  dec,
   output logic              valid_ff,
   output trp_pkg::sum_type  sum_ff
);
   import trp_pkg::*;

   logic        valid_in;
   sum_type     sum_in;
   logic [31:0] opa;
   logic [31:0] opb;
   logic        cin;

   always_comb begin
      case (dec.op)
         OP_ABS32: begin
            opa = dec.word;
            opb = dec.sym;
            cin = 1'b0;
         end
         OP_BRANCH: begin
            // sym - (place + 4)
            opa = dec.sym;
            opb = ~dec.place4;
            cin = 1'b1;
         end
         OP_MOVW, OP_MOVT: begin
            opa = dec.sym;
            opb = dec.addend;
            cin = 1'b0;
         end
         default: begin
            opa = dec.word;
            opb = '0;
            cin = 1'b0;
         end
      endcase
   end

   always_comb begin
      valid_in    = valid;
      sum_in.op   = dec.op;
      sum_in.word = dec.word;
      sum_in.sum  = opa + opb + {31'd0, cin};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
   end

endmodule

/* hw/rtl/trp_format.sv */
// Stage 3: range check, field insertion and the result register.
module trp_format (
   input  logic              clock,
   input  logic              reset,
   input  logic              valid,
   input  trp_pkg::sum_type  sum,
   output logic              valid_ff,
   output trp_pkg::rsp_type  rsp_ff
);
   import trp_pkg::*;

   logic        valid_in;
   rsp_type     rsp_in;
   logic [31:0] d;
   logic [31:0] w;
   logic        in_range;
   logic        s;
   logic        j1;
   logic        j2;
   logic [15:0] v16;
   logic [31:0] br_word;
   logic [31:0] mov_word;

   assign d = sum.sum;
   assign w = sum.word;

   // offset fits in 25 signed bits when bits 31:24 agree
   assign in_range = (d[31:24] == 8'h00) || (d[31:24] == 8'hFF);
   assign s        = d[24];
   assign j1       = ~(d[23] ^ s);
   assign j2       = ~(d[22] ^ s);
   assign br_word  = {w[31:30], j1, w[28], j2, d[11:1],
                      w[15:11], s, d[21:12]};

   assign v16      = (sum.op == OP_MOVT) ? d[31:16] : d[15:0];
   assign mov_word = {1'b0, v16[10:8], w[27:24], v16[7:0],
                      w[15:11], v16[11], w[9:4], v16[15:12]};

   always_comb begin
      rsp_in.patched_word = w;
      rsp_in.status       = ST_OK;
      case (sum.op)
         OP_ABS32: begin
            rsp_in.patched_word = d;
         end
         OP_BRANCH: begin
            if (in_range) begin
               rsp_in.patched_word = br_word;
            end else begin
               rsp_in.status = ST_RANGE;
            end
         end
         OP_MOVW, OP_MOVT: begin
            rsp_in.patched_word = mov_word;
         end
         default: begin
            rsp_in.status = ST_UNSUPPORTED;
         end
      endcase
   end

   assign valid_in = valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule

/* hw/rtl/thumb_relocation_patcher.sv */
// Top level of the Thumb/ARM ELF relocation patcher pipeline.
// rsp_strobe rises once a request has passed the decode, adder and format registers.
// Throughput: 1 request per cycle through the three register stages (decode, adder, format).
// busy stays low: the pipeline has no stall path, since results cannot be held off.
// Reset (synchronous, active high) clears the stage valid bits; payload is not reset.
module thumb_relocation_patcher (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  trp_pkg::req_type  req_payload,
   output logic              rsp_strobe,
   output trp_pkg::rsp_type  rsp_payload
);
   import trp_pkg::*;

   logic    accept;
   logic    dec_valid;
   dec_type dec;
   logic    sum_valid;
   sum_type sum;

   // Every cycle can take a new request.
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Stage 1: decode the type, pull the MOVW/MOVT addend, form place + 4.
   trp_decode u_decode (
      .clock    (clock),
      .reset    (reset),
      .valid    (accept),
      .req      (req_payload),
      .valid_ff (dec_valid),
      .dec_ff   (dec)
   );

   // Stage 2: single 32-bit adder (word + sym, sym + addend or sym - place - 4).
   trp_arith u_arith (
      .clock    (clock),
      .reset    (reset),
      .valid    (dec_valid),
      .dec      (dec),
      .valid_ff (sum_valid),
      .sum_ff   (sum)
   );

   // Stage 3: branch range check, bit-field insertion, status; output register.
   trp_format u_format (
      .clock    (clock),
      .reset    (reset),
      .valid    (sum_valid),
      .sum      (sum),
      .valid_ff (rsp_strobe),
      .rsp_ff   (rsp_payload)
   );

endmodule

/* hw/rtl/trp_checker.sv */
// Port-level checker of the relocation patcher, bound to the top level.
module trp_port_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  trp_pkg::req_type  req_payload,
   input  logic              rsp_strobe,
   input  trp_pkg::rsp_type  rsp_payload
);
   import trp_pkg::*;

   // Every accepted request yields a result after the decode, adder and format registers.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##3 rsp_strobe)
      else $error("request without result after 3 cycles");

   // No result without a request that has passed the decode, adder and format registers.
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 3))
      else $error("result without matching request");

   // Status is one of the three defined codes.
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_payload.status == ST_OK || rsp_payload.status == ST_RANGE ||
                      rsp_payload.status == ST_UNSUPPORTED))
      else $error("undefined status code");

   // Any error returns the original word.
   a_err_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.status != ST_OK) |->
         rsp_payload.patched_word == $past(req_payload.insn_word, 3))
      else $error("error result changed the word");

   // Unknown type codes always report unsupported.
   a_unsup: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ((rsp_payload.status == ST_UNSUPPORTED) ==
         ($past(req_payload.action, 3) != TYPE_ABS32 &&
          $past(req_payload.action, 3) != TYPE_THM_CALL &&
          $past(req_payload.action, 3) != TYPE_THM_JUMP24 &&
          $past(req_payload.action, 3) != TYPE_THM_MOVW &&
          $past(req_payload.action, 3) != TYPE_THM_MOVT)))
      else $error("unsupported status mismatch");

endmodule

bind thumb_relocation_patcher trp_port_checker u_trp_port_checker (.*);

/* dv/trp_checker.sv */
`timescale 1ns / 1ps
// Checker for the relocation patcher: predicts each patch and compares the responses.
module trp_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  trp_pkg::req_type req_payload,
   input  logic             rsp_strobe,
   input  trp_pkg::rsp_type rsp_payload,
   output int               failures,
   output int               pending,
   output int               checked_count,
   output int               range_count,
   output int               unsupported_count
);
   import trp_pkg::*;

   rsp_type expected_patches[$];

   // Patched word and status for one relocation request.
   function automatic rsp_type patch_relocation(input req_type r);
      logic [31:0] offset;
      logic [31:0] biased;
      logic [31:0] value;
      logic [15:0] lo;
      logic [15:0] hi;
      logic [15:0] imm16;
      logic [15:0] v16;
      rsp_type     p;
      p.patched_word = r.insn_word;
      p.status       = ST_OK;
      lo = r.insn_word[15:0];
      hi = r.insn_word[31:16];
      case (r.action)
         TYPE_ABS32: begin
            p.patched_word = r.insn_word + r.symbol_address;
         end
         TYPE_THM_CALL, TYPE_THM_JUMP24: begin
            offset = r.symbol_address - r.place_address - PC_OFFSET;
            biased = offset + 32'h0100_0000;
            if (biased >= 32'h0200_0000) begin
               p.status = ST_RANGE;
            end else begin
               // second half: keep 15,14,12; J1, J2, imm11. first half: keep 15:11; S, imm10
               p.patched_word = {hi[15:14], ~(offset[23] ^ offset[24]), hi[12],
                                 ~(offset[22] ^ offset[24]), offset[11:1],
                                 lo[15:11], offset[24], offset[21:12]};
            end
         end
         TYPE_THM_MOVW, TYPE_THM_MOVT: begin
            imm16 = {lo[3:0], lo[10], hi[14:12], hi[7:0]};
            value = r.symbol_address + {{16{imm16[15]}}, imm16};
            v16   = (r.action == TYPE_THM_MOVT) ? value[31:16] : value[15:0];
            p.patched_word = {1'b0, v16[10:8], hi[11:8], v16[7:0],
                              lo[15:11], v16[11], lo[9:4], v16[15:12]};
         end
         default: begin
            p.status = ST_UNSUPPORTED;
         end
      endcase
      return p;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         expected_patches.delete();
         failures          <= 0;
         pending           <= 0;
         checked_count     <= 0;
         range_count       <= 0;
         unsupported_count <= 0;
      end else begin
         // responses first, so a strobe can never match the request taken at this edge
         if (rsp_strobe) begin
            if (expected_patches.size() == 0) begin
               $error("response with no request outstanding: word %08h status %0d",
                      rsp_payload.patched_word, rsp_payload.status);
               failures <= failures + 1;
            end else begin
               want = expected_patches.pop_front();
               checked_count <= checked_count + 1;
               if (want.status == ST_RANGE)
                  range_count <= range_count + 1;
               if (want.status == ST_UNSUPPORTED)
                  unsupported_count <= unsupported_count + 1;
               if (rsp_payload.patched_word !== want.patched_word ||
                   rsp_payload.status !== want.status) begin
                  if (rsp_payload.patched_word !== want.patched_word)
                     $error("patched_word: expected %08h, got %08h",
                            want.patched_word, rsp_payload.patched_word);
                  if (rsp_payload.status !== want.status)
                     $error("status: expected %0d, got %0d",
                            want.status, rsp_payload.status);
                  failures <= failures + 1;
               end
            end
         end
         if (start && !busy)
            expected_patches.push_back(patch_relocation(req_payload));
         pending <= expected_patches.size();
      end
   end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// Testbench top for the relocation patcher: clock, reset, request stimulus and verdict.
module tb_top;
   import trp_pkg::*;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_payload;
   logic    rsp_strobe;
   rsp_type rsp_payload;

   int failures;
   int pending;
   int checked_count;
   int range_count;
   int unsupported_count;

   // requests left in the current burst before the sender idles
   int burst_left;

   thumb_relocation_patcher dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

   // Predicts and compares on its own; the top only drives and decides.
   trp_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_payload       (req_payload),
      .rsp_strobe        (rsp_strobe),
      .rsp_payload       (rsp_payload),
      .failures          (failures),
      .pending           (pending),
      .checked_count     (checked_count),
      .range_count       (range_count),
      .unsupported_count (unsupported_count)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Hard stop in case the pipeline hangs.
   initial begin
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic req_type make_request(input logic [7:0] action, input logic [31:0] word,
                                            input logic [31:0] place, input logic [31:0] sym);
      req_type r;
      r.action         = action;
      r.insn_word      = word;
      r.place_address  = place;
      r.symbol_address = sym;
      return r;
   endfunction

   // Hands one request over. Between bursts start drops for a random gap and the
   // payload carries junk, which the block must ignore. Inside a burst start
   // stays high, so back-to-back requests get no dead cycle.
   task automatic send_request(input req_type r);
      int           idle;
      logic [127:0] junk;
      if (burst_left == 0) begin
         idle = $urandom_range(1, 8);
         junk = {$urandom, $urandom, $urandom, $urandom};
         start       <= 1'b0;
         req_payload <= junk[$bits(req_type)-1:0];
         repeat (idle) @(posedge clock);
         // now and then a long stretch with no idling at all
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                 : $urandom_range(1, 12);
      end
      start       <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      burst_left--;
   endtask

   // Random relocation, weighted toward the supported types. Branch targets are
   // mostly placed within reach of the site so the field packing gets exercised,
   // with a share right at the range limits and some anywhere in memory.
   task automatic send_random();
      logic [7:0]  action;
      logic [31:0] place;
      logic [31:0] offset;
      logic [24:0] near;
      logic [7:0]  neighbors[8];
      int          pick;
      neighbors = '{8'd1, 8'd3, 8'd9, 8'd11, 8'd29, 8'd31, 8'd46, 8'd49};
      place = $urandom;
      pick  = $urandom_range(0, 99);
      if (pick < 15)
         action = TYPE_ABS32;
      else if (pick < 40)
         action = $urandom_range(0, 1) ? TYPE_THM_CALL : TYPE_THM_JUMP24;
      else if (pick < 55)
         action = TYPE_THM_MOVW;
      else if (pick < 70)
         action = TYPE_THM_MOVT;
      else if (pick < 80)
         action = neighbors[$urandom_range(0, 7)];
      else
         action = 8'($urandom_range(0, 255));
      case ($urandom_range(0, 3))
         0: begin
            offset = $urandom;
         end
         1: begin
            offset = ($urandom_range(0, 1) ? 32'h0100_0000 : 32'hFF00_0000)
                     + $urandom_range(0, 7) - 32'd4;
         end
         default: begin
            near   = 25'($urandom);
            offset = {{7{near[24]}}, near};
         end
      endcase
      send_request(make_request(action, $urandom, place, place + PC_OFFSET + offset));
   endtask

   initial begin
      int drain;
      reset       = 1'b1;
      start       = 1'b0;
      req_payload = '0;
      burst_left  = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // ABS32: zero, full wrap, top bit of the symbol
      send_request(make_request(TYPE_ABS32, 32'h0000_0000, 32'h0, 32'h0000_0000));
      send_request(make_request(TYPE_ABS32, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF));
      send_request(make_request(TYPE_ABS32, 32'h1234_5678, 32'h0, 32'h8000_0000));
      // BL, ordinary forward call
      send_request(make_request(TYPE_THM_CALL, 32'hF800_F000, 32'h0000_1000, 32'h0000_2000));
      // farthest forward offset, odd offset, first one past the limit
      send_request(make_request(TYPE_THM_CALL, 32'hF800_F000, 32'h0, 32'h0100_0002));
      send_request(make_request(TYPE_THM_CALL, 32'hF800_F000, 32'h0, 32'h0100_0003));
      send_request(make_request(TYPE_THM_CALL, 32'hF800_F000, 32'h0, 32'h0100_0004));
      // B.W at the farthest backward offset, then one step beyond it
      send_request(make_request(TYPE_THM_JUMP24, 32'h9000_F000, 32'h0200_0000,
                                32'h0100_0004));
      send_request(make_request(TYPE_THM_JUMP24, 32'h9000_F000, 32'h0200_0000,
                                32'h0100_0002));
      // target across the top of the address space
      send_request(make_request(TYPE_THM_JUMP24, 32'h9000_F000, 32'hFFFF_FFF0,
                                32'h0000_0010));
      // BLX form, short backward call
      send_request(make_request(TYPE_THM_CALL, 32'hE800_F000, 32'h0000_0100, 32'h0000_0080));
      // zero offset with every kept bit set, then the -4 offset on an empty word
      send_request(make_request(TYPE_THM_CALL, 32'hFFFF_FFFF, 32'hFFFF_FFFC, 32'h0));
      send_request(make_request(TYPE_THM_CALL, 32'h0000_0000, 32'h0, 32'h0));
      // MOVW: empty word, addend of -1, most negative addend
      send_request(make_request(TYPE_THM_MOVW, 32'h0000_0000, 32'h0, 32'hFFFF_FFFF));
      send_request(make_request(TYPE_THM_MOVW, 32'hFFFF_FFFF, 32'h0, 32'h0000_0000));
      send_request(make_request(TYPE_THM_MOVW, 32'h0000_F248, 32'h0, 32'h1234_5678));
      // MOVT: plain, sum wrapping below zero, carry into the high half
      send_request(make_request(TYPE_THM_MOVT, 32'h0000_F2C0, 32'h0, 32'hDEAD_BEEF));
      send_request(make_request(TYPE_THM_MOVT, 32'hFFFF_FFFF, 32'h0, 32'h0000_0000));
      send_request(make_request(TYPE_THM_MOVT, 32'h70FF_F647, 32'h0, 32'hFFFF_8001));
      // unsupported codes, including the neighbors of supported ones
      send_request(make_request(8'd0, 32'hA5A5_5A5A, 32'h0, 32'h0));
      send_request(make_request(8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_request(make_request(8'd1, 32'h0000_0001, 32'h0, 32'h1));
      send_request(make_request(8'd3, 32'h8000_0000, 32'h0, 32'h1));
      send_request(make_request(8'd31, 32'h9000_F000, 32'h0, 32'h100));
      send_request(make_request(8'd49, 32'h0000_F2C0, 32'h0, 32'h100));

      repeat (600) send_random();

      start <= 1'b0;
      @(posedge clock);
      // wait out the responses still in the pipe, bounded
      drain = 0;
      while (pending != 0 && drain < 200) begin
         @(posedge clock);
         drain++;
      end
      // wait on past the 3-stage pipeline, to catch stray strobes
      repeat (8) @(posedge clock);

      if (pending != 0)
         $error("%0d expected responses never arrived", pending);
      $display("Summary: %0d relocations checked, %0d branches out of range, %0d bad types",
               checked_count, range_count, unsupported_count);
      if (failures == 0 && pending == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
